// ===== src/irq_priority_task_queue_unit_assert.svh =====
// Assertion macros used by the checker of the task queue unit.
`ifndef IRQ_PRIORITY_TASK_QUEUE_UNIT_ASSERT_SVH
`define IRQ_PRIORITY_TASK_QUEUE_UNIT_ASSERT_SVH

// Check that a condition implies another condition in the same cycle.
`define IPTQ_ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that a condition implies another condition in the next cycle.
`define IPTQ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/iptq_pkg.sv =====
// -----------------------------------------------------------------------------
// iptq_pkg
// Shared constants, codes and controller/datapath interface types of the
// interrupt priority task queue.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iptq_pkg;

    // Table geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths
    localparam int TAG_W       = 3;
    localparam int PRIO_W      = 8;
    localparam int HANDLER_W   = 2;
    localparam int CAUSE_W     = 2;
    localparam int QCOUNT_W    = 4;

    // Operation codes
    localparam logic OP_IRQ  = 1'b0;
    localparam logic OP_DONE = 1'b1;

    // UART identify codes
    localparam logic [CAUSE_W-1:0] CAUSE_TX = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_RX = 2'd2;

    // Handler codes
    localparam logic [HANDLER_W-1:0] HANDLER_UART_TX = 2'd0;
    localparam logic [HANDLER_W-1:0] HANDLER_UART_RX = 2'd1;
    localparam logic [HANDLER_W-1:0] HANDLER_TIMER   = 2'd2;

    // Configuration register indexes
    localparam logic REG_UART_PRIO  = 1'b0;
    localparam logic REG_TIMER_PRIO = 1'b1;

    // Reset values of the configuration registers
    localparam logic [PRIO_W-1:0] UART_PRIO_RESET  = 8'd0;
    localparam logic [PRIO_W-1:0] TIMER_PRIO_RESET = 8'd255;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;     // capture the request and decode it
        logic eval;      // record the drop decision
        logic scan_inc;  // advance the queue position
        logic do_insert; // insert the new task at the scan position
        logic do_remove; // remove the entry at the scan position
        logic do_head;   // start the head and load the result
    } iptq_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_done;   // latched request is a done event
        logic want;      // interrupt asks for a new task
        logic full;      // no room for a new task
        logic remove_ok; // done tag names a busy task
        logic scan_stop; // scan position reached its target
    } iptq_status_t;

endpackage

// ===== src/irq_priority_task_queue_unit.sv =====
// The queue is walked one position per cycle to find the insert point or the finished task.
// busy stays high until the head check is done; result_valid pulses in the cycle after,
// and the next start can be taken in that cycle. The receiver cannot stall.
// Asynchronous active-low reset empties the table and loads the default priorities.
// -----------------------------------------------------------------------------
// irq_priority_task_queue_unit
// Interrupt priority task queue: masks the interrupting source, queues its
// handler by priority, removes finished tasks and starts the most urgent task.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irq_priority_task_queue_unit
    import iptq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request
    input  logic                 start,
    output logic                 busy,
    input  logic                 op,
    input  logic                 uart_pending,
    input  logic [CAUSE_W-1:0]   uart_cause,
    input  logic                 timer_pending,
    input  logic [TAG_W-1:0]     done_tag,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [PRIO_W-1:0]    cfg_data,
    // result
    output logic                 result_valid,
    output logic                 mask_uart_tx,
    output logic                 mask_uart_rx,
    output logic                 mask_timer,
    output logic                 start_valid,
    output logic [HANDLER_W-1:0] start_handler,
    output logic [TAG_W-1:0]     start_tag,
    output logic                 dropped,
    output logic [QCOUNT_W-1:0]  queued_count
);

    iptq_cmd_t    cmd;
    iptq_status_t status;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    iptq_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .result_valid (result_valid),
        .cmd          (cmd),
        .status       (status)
    );

    iptq_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .op            (op),
        .uart_pending  (uart_pending),
        .uart_cause    (uart_cause),
        .timer_pending (timer_pending),
        .done_tag      (done_tag),
        .cmd           (cmd),
        .status        (status),
        .mask_uart_tx  (mask_uart_tx),
        .mask_uart_rx  (mask_uart_rx),
        .mask_timer    (mask_timer),
        .start_valid   (start_valid),
        .start_handler (start_handler),
        .start_tag     (start_tag),
        .dropped       (dropped),
        .queued_count  (queued_count)
    );

endmodule

// ===== src/iptq_ctrl.sv =====
// -----------------------------------------------------------------------------
// iptq_ctrl
// Sequencer of the task queue: decode, walk the queue, update it, start the
// head and strobe the result.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iptq_ctrl
    import iptq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    output logic         result_valid,
    output iptq_cmd_t    cmd,
    input  iptq_status_t status
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_HEAD   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       strobe_reg;
    logic       strobe_next;

    // Compute next state and commands
    always_comb
    begin
        state_next  = state_reg;
        strobe_next = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.is_done)
                begin
                    state_next = status.remove_ok ? S_SCAN : S_HEAD;
                end
                else
                begin
                    state_next = (status.want && !status.full) ? S_SCAN : S_HEAD;
                end
            end
            S_SCAN:
            begin
                if (status.scan_stop)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_UPDATE:
            begin
                cmd.do_insert = !status.is_done;
                cmd.do_remove = status.is_done;
                state_next    = S_HEAD;
            end
            S_HEAD:
            begin
                cmd.do_head = 1'b1;
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = strobe_reg;

endmodule

// ===== src/iptq_datapath.sv =====
// -----------------------------------------------------------------------------
// iptq_datapath
// Task table, run-order list, configuration registers, scan position and
// result registers of the task queue.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iptq_datapath
    import iptq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [PRIO_W-1:0]    cfg_data,
    // request
    input  logic                 op,
    input  logic                 uart_pending,
    input  logic [CAUSE_W-1:0]   uart_cause,
    input  logic                 timer_pending,
    input  logic [TAG_W-1:0]     done_tag,
    // control
    input  iptq_cmd_t            cmd,
    output iptq_status_t         status,
    // result
    output logic                 mask_uart_tx,
    output logic                 mask_uart_rx,
    output logic                 mask_timer,
    output logic                 start_valid,
    output logic [HANDLER_W-1:0] start_handler,
    output logic [TAG_W-1:0]     start_tag,
    output logic                 dropped,
    output logic [QCOUNT_W-1:0]  queued_count
);

    // Configuration registers
    logic [PRIO_W-1:0] uart_prio_reg;
    logic [PRIO_W-1:0] timer_prio_reg;

    // Task table and run order
    logic [QUEUE_DEPTH-1:0] valid_reg;
    logic [QUEUE_DEPTH-1:0] valid_next;
    logic [QUEUE_DEPTH-1:0] busy_reg;
    logic [QUEUE_DEPTH-1:0] busy_next;
    logic [HANDLER_W-1:0]   handler_reg [QUEUE_DEPTH];
    logic [PRIO_W-1:0]      prio_reg    [QUEUE_DEPTH];
    logic [SLOT_W-1:0]      order_reg   [QUEUE_DEPTH];
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     count_next;

    // Latched request
    logic                 is_done_reg;
    logic                 m_tx_reg;
    logic                 m_rx_reg;
    logic                 m_tm_reg;
    logic [HANDLER_W-1:0] new_handler_reg;
    logic [PRIO_W-1:0]    new_prio_reg;
    logic [TAG_W-1:0]     done_tag_reg;
    logic                 drop_reg;
    logic [COUNT_W-1:0]   pos_reg;

    // Result registers
    logic                 out_tx_reg;
    logic                 out_rx_reg;
    logic                 out_tm_reg;
    logic                 out_start_reg;
    logic [HANDLER_W-1:0] out_handler_reg;
    logic [TAG_W-1:0]     out_tag_reg;
    logic                 out_drop_reg;
    logic [QCOUNT_W-1:0]  out_count_reg;

    // Decode of the incoming request
    logic                 dec_tx;
    logic                 dec_rx;
    logic                 dec_tm;
    logic                 want;
    logic [SLOT_W-1:0]    free_slot;
    logic                 free_found;
    logic                 full;
    logic [SLOT_W-1:0]    done_slot;
    logic                 remove_ok;
    logic [SLOT_W-1:0]    pos_idx;
    logic [SLOT_W-1:0]    scan_slot;
    logic                 scan_stop;
    logic [SLOT_W-1:0]    head_slot;
    logic                 head_start;

    assign dec_tx = (op == OP_IRQ) && uart_pending && (uart_cause == CAUSE_TX);
    assign dec_rx = (op == OP_IRQ) && uart_pending && (uart_cause == CAUSE_RX);
    assign dec_tm = (op == OP_IRQ) && !uart_pending && timer_pending;
    assign want   = m_tx_reg || m_rx_reg || m_tm_reg;

    // Find the lowest numbered free slot
    always_comb
    begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot  = SLOT_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign full      = (count_reg >= COUNT_W'(QUEUE_DEPTH)) || !free_found;
    assign done_slot = SLOT_W'(done_tag_reg);
    assign remove_ok = (int'(done_tag_reg) < QUEUE_DEPTH)
                       && valid_reg[done_slot] && busy_reg[done_slot];

    // Scan stops at the insert point or at the finished entry
    assign pos_idx   = pos_reg[SLOT_W-1:0];
    assign scan_slot = order_reg[pos_idx];
    always_comb
    begin
        if (pos_reg == count_reg)
        begin
            scan_stop = 1'b1;
        end
        else if (is_done_reg)
        begin
            scan_stop = (scan_slot == done_slot);
        end
        else
        begin
            scan_stop = (prio_reg[scan_slot] > new_prio_reg);
        end
    end

    assign head_slot  = order_reg[0];
    assign head_start = (count_reg != '0) && !busy_reg[head_slot];

    assign status.is_done   = is_done_reg;
    assign status.want      = want;
    assign status.full      = full;
    assign status.remove_ok = remove_ok;
    assign status.scan_stop = scan_stop;

    // Next table flags and count
    always_comb
    begin
        valid_next = valid_reg;
        busy_next  = busy_reg;
        count_next = count_reg;
        if (cmd.do_insert)
        begin
            valid_next[free_slot] = 1'b1;
            busy_next[free_slot]  = 1'b0;
            count_next            = count_reg + COUNT_W'(1);
        end
        else if (cmd.do_remove)
        begin
            valid_next[done_slot] = 1'b0;
            busy_next[done_slot]  = 1'b0;
            count_next            = count_reg - COUNT_W'(1);
        end
        else if (cmd.do_head && head_start)
        begin
            busy_next[head_slot] = 1'b1;
        end
    end

    // Hold configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uart_prio_reg  <= UART_PRIO_RESET;
            timer_prio_reg <= TIMER_PRIO_RESET;
            valid_reg      <= '0;
            busy_reg       <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_UART_PRIO))
            begin
                uart_prio_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_TIMER_PRIO))
            begin
                timer_prio_reg <= cfg_data;
            end
            valid_reg <= valid_next;
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    // Capture the request, advance the scan, record the drop
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            is_done_reg  <= (op == OP_DONE);
            m_tx_reg     <= dec_tx;
            m_rx_reg     <= dec_rx;
            m_tm_reg     <= dec_tm;
            done_tag_reg <= done_tag;
            pos_reg      <= '0;
            if (dec_tm)
            begin
                new_handler_reg <= HANDLER_TIMER;
                new_prio_reg    <= timer_prio_reg;
            end
            else
            begin
                new_handler_reg <= dec_rx ? HANDLER_UART_RX : HANDLER_UART_TX;
                new_prio_reg    <= uart_prio_reg;
            end
        end
        if (cmd.eval)
        begin
            drop_reg <= !is_done_reg && want && full;
        end
        if (cmd.scan_inc)
        begin
            pos_reg <= pos_reg + COUNT_W'(1);
        end
    end

    // Update the slot payload and shift the run order
    always_ff @(posedge clk)
    begin
        if (cmd.do_insert)
        begin
            handler_reg[free_slot] <= new_handler_reg;
            prio_reg[free_slot]    <= new_prio_reg;
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (i == int'(pos_reg))
                begin
                    order_reg[i] <= free_slot;
                end
                else if ((i > int'(pos_reg)) && (i > 0))
                begin
                    order_reg[i] <= order_reg[i-1];
                end
            end
        end
        else if (cmd.do_remove)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                if (i >= int'(pos_reg))
                begin
                    order_reg[i] <= order_reg[i+1];
                end
            end
        end
    end

    // Load the result
    always_ff @(posedge clk)
    begin
        if (cmd.do_head)
        begin
            out_tx_reg      <= m_tx_reg;
            out_rx_reg      <= m_rx_reg;
            out_tm_reg      <= m_tm_reg;
            out_drop_reg    <= drop_reg;
            out_count_reg   <= QCOUNT_W'(count_reg);
            out_start_reg   <= head_start;
            out_handler_reg <= head_start ? handler_reg[head_slot] : HANDLER_UART_TX;
            out_tag_reg     <= head_start ? TAG_W'(head_slot) : '0;
        end
    end

    assign mask_uart_tx  = out_tx_reg;
    assign mask_uart_rx  = out_rx_reg;
    assign mask_timer    = out_tm_reg;
    assign start_valid   = out_start_reg;
    assign start_handler = out_handler_reg;
    assign start_tag     = out_tag_reg;
    assign dropped       = out_drop_reg;
    assign queued_count  = out_count_reg;

endmodule

// ===== src/iptq_checker.sv =====
// -----------------------------------------------------------------------------
// iptq_checker
// Port-level checks of the task queue unit, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "irq_priority_task_queue_unit_assert.svh"

module iptq_checker
    import iptq_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 result_valid,
    input logic                 mask_uart_tx,
    input logic                 mask_uart_rx,
    input logic                 mask_timer,
    input logic                 start_valid,
    input logic [HANDLER_W-1:0] start_handler,
    input logic                 dropped,
    input logic [QCOUNT_W-1:0]  queued_count
);

    // An accepted request keeps the unit busy
    `IPTQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "request not held")

    // At most one source is masked per result
    `IPTQ_ASSERT_SAME(a_one_mask, clk, rst_n, result_valid,
        $onehot0({mask_uart_tx, mask_uart_rx, mask_timer}), "several sources masked")

    // A drop happens only with a full table
    `IPTQ_ASSERT_SAME(a_drop_full, clk, rst_n, result_valid && dropped,
        (queued_count == QCOUNT_W'(QUEUE_DEPTH)), "drop with room left")

    // A started task uses a known handler
    `IPTQ_ASSERT_SAME(a_handler_known, clk, rst_n, result_valid && start_valid,
        (start_handler == HANDLER_UART_TX) || (start_handler == HANDLER_UART_RX)
        || (start_handler == HANDLER_TIMER), "unknown handler started")

endmodule

bind irq_priority_task_queue_unit iptq_checker u_iptq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_valid  (result_valid),
    .mask_uart_tx  (mask_uart_tx),
    .mask_uart_rx  (mask_uart_rx),
    .mask_timer    (mask_timer),
    .start_valid   (start_valid),
    .start_handler (start_handler),
    .dropped       (dropped),
    .queued_count  (queued_count)
);

// ===== bench/irq_priority_task_queue_unit_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// irq_priority_task_queue_unit_tb
// Self-checking bench for the interrupt priority task queue. A driver feeds
// interrupt and done requests from a queue with random idle gaps, and writes
// the priority registers between drained phases. A monitor keeps its own copy
// of the task table, predicts each result when a request is taken and checks
// every result field against the oldest prediction.
// -----------------------------------------------------------------------------

module irq_priority_task_queue_unit_tb;

    import iptq_pkg::*;

    localparam int RUN_LIMIT   = 200000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 150;
    localparam int MAX_REPORTS = 40;

    typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} action_t;

    typedef struct {
        action_t              kind;
        logic                 op;
        logic                 uart_pending;
        logic [CAUSE_W-1:0]   uart_cause;
        logic                 timer_pending;
        logic [TAG_W-1:0]     done_tag;
        logic                 aim_busy;
        logic                 cfg_index;
        logic [PRIO_W-1:0]    cfg_data;
        int                   gap;
    } request_t;

    typedef struct packed {
        logic                 mask_tx;
        logic                 mask_rx;
        logic                 mask_tm;
        logic                 s_valid;
        logic [HANDLER_W-1:0] s_handler;
        logic [TAG_W-1:0]     s_tag;
        logic                 drop;
        logic [QCOUNT_W-1:0]  count;
    } step_outcome_t;

    // DUT signals
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 op = 1'b0;
    logic                 uart_pending = 1'b0;
    logic [CAUSE_W-1:0]   uart_cause = '0;
    logic                 timer_pending = 1'b0;
    logic [TAG_W-1:0]     done_tag = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = 1'b0;
    logic [PRIO_W-1:0]    cfg_data = '0;
    logic                 result_valid;
    logic                 mask_uart_tx;
    logic                 mask_uart_rx;
    logic                 mask_timer;
    logic                 start_valid;
    logic [HANDLER_W-1:0] start_handler;
    logic [TAG_W-1:0]     start_tag;
    logic                 dropped;
    logic [QCOUNT_W-1:0]  queued_count;

    // Predicted task table and priorities
    logic                 tq_valid   [QUEUE_DEPTH] = '{default: 1'b0};
    logic                 tq_busy    [QUEUE_DEPTH] = '{default: 1'b0};
    logic [HANDLER_W-1:0] tq_handler [QUEUE_DEPTH] = '{default: '0};
    logic [PRIO_W-1:0]    tq_prio    [QUEUE_DEPTH] = '{default: '0};
    logic [TAG_W-1:0]     tq_order   [QUEUE_DEPTH] = '{default: '0};
    int                   task_cnt = 0;
    logic [PRIO_W-1:0]    uart_prio  = UART_PRIO_RESET;
    logic [PRIO_W-1:0]    timer_prio = TIMER_PRIO_RESET;

    request_t             request_q[$];
    step_outcome_t        outcome_q[$];
    logic                 req_taken = 1'b0;
    logic                 cfg_taken = 1'b0;
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    int                   burst_left = 0;
    int                   gap_left = 0;
    logic                 gap_loaded = 1'b0;

    irq_priority_task_queue_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .uart_pending  (uart_pending),
        .uart_cause    (uart_cause),
        .timer_pending (timer_pending),
        .done_tag      (done_tag),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .mask_uart_tx  (mask_uart_tx),
        .mask_uart_rx  (mask_uart_rx),
        .mask_timer    (mask_timer),
        .start_valid   (start_valid),
        .start_handler (start_handler),
        .start_tag     (start_tag),
        .dropped       (dropped),
        .queued_count  (queued_count)
    );

    // Clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one request to the predicted table and return the result it yields
    function automatic step_outcome_t advance_task_table(
        logic                 req_op,
        logic                 req_uart,
        logic [CAUSE_W-1:0]   req_cause,
        logic                 req_timer,
        logic [TAG_W-1:0]     req_tag
    );
        step_outcome_t        o;
        logic                 want;
        logic [HANDLER_W-1:0] hnd;
        logic [PRIO_W-1:0]    prio;
        int                   slot;
        int                   pos;
        int                   i;
        logic [TAG_W-1:0]     head;

        o    = '0;
        want = 1'b0;
        hnd  = HANDLER_UART_TX;
        prio = '0;
        if (req_op == OP_IRQ)
        begin
            // UART wins; an unknown UART cause swallows the event
            if (req_uart)
            begin
                if (req_cause == CAUSE_TX)
                begin
                    o.mask_tx = 1'b1;
                    want      = 1'b1;
                    hnd       = HANDLER_UART_TX;
                    prio      = uart_prio;
                end
                else if (req_cause == CAUSE_RX)
                begin
                    o.mask_rx = 1'b1;
                    want      = 1'b1;
                    hnd       = HANDLER_UART_RX;
                    prio      = uart_prio;
                end
            end
            else if (req_timer)
            begin
                o.mask_tm = 1'b1;
                want      = 1'b1;
                hnd       = HANDLER_TIMER;
                prio      = timer_prio;
            end
            // Insert after every task of equal or more urgent priority
            if (want)
            begin
                if (task_cnt >= QUEUE_DEPTH)
                    o.drop = 1'b1;
                else
                begin
                    slot = 0;
                    while (slot < QUEUE_DEPTH && tq_valid[slot])
                        slot++;
                    pos = 0;
                    while (pos < task_cnt && tq_prio[tq_order[pos]] <= prio)
                        pos++;
                    for (i = task_cnt; i > pos; i--)
                        tq_order[i] = tq_order[i-1];
                    tq_order[pos]    = slot[TAG_W-1:0];
                    tq_valid[slot]   = 1'b1;
                    tq_busy[slot]    = 1'b0;
                    tq_handler[slot] = hnd;
                    tq_prio[slot]    = prio;
                    task_cnt++;
                end
            end
        end
        else if (tq_valid[req_tag] && tq_busy[req_tag])
        begin
            // Drop the finished task from wherever it sits
            pos = 0;
            while (pos < task_cnt && tq_order[pos] != req_tag)
                pos++;
            if (pos < task_cnt)
            begin
                for (i = pos; i + 1 < task_cnt; i++)
                    tq_order[i] = tq_order[i+1];
                task_cnt--;
                tq_valid[req_tag] = 1'b0;
                tq_busy[req_tag]  = 1'b0;
            end
        end

        // Start the head if it is idle
        if (task_cnt > 0)
        begin
            head = tq_order[0];
            if (!tq_busy[head])
            begin
                tq_busy[head] = 1'b1;
                o.s_valid     = 1'b1;
                o.s_handler   = tq_handler[head];
                o.s_tag       = head;
            end
        end
        o.count = task_cnt[QCOUNT_W-1:0];
        return o;
    endfunction

    // Pick a running task to finish, or keep the random tag if none runs
    function automatic logic [TAG_W-1:0] pick_busy_slot(logic [TAG_W-1:0] fallback);
        logic [TAG_W-1:0] cand[$];
        int               s;

        for (s = 0; s < QUEUE_DEPTH; s++)
            if (tq_valid[s] && tq_busy[s])
                cand.push_back(s[TAG_W-1:0]);
        if (cand.size() == 0)
            return fallback;
        return cand[$urandom_range(cand.size() - 1)];
    endfunction

    // Idle cycles before a request, with stretches of back-to-back traffic
    function automatic int draw_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(19) == 0)
            burst_left = $urandom_range(40, 10);
        return $urandom_range(12);
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, int got, int want_v);
        if (got != want_v)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want_v));
    endtask

    task automatic push_irq(logic up, logic [CAUSE_W-1:0] cause, logic tp);
        request_t r;

        r               = '{kind: ACT_ITEM, default: '0};
        r.op            = OP_IRQ;
        r.uart_pending  = up;
        r.uart_cause    = cause;
        r.timer_pending = tp;
        r.done_tag      = TAG_W'($urandom_range(7));
        r.gap           = draw_gap();
        request_q.push_back(r);
    endtask

    task automatic push_done(logic [TAG_W-1:0] tag, logic aim);
        request_t r;

        r               = '{kind: ACT_ITEM, default: '0};
        r.op            = OP_DONE;
        r.uart_pending  = 1'($urandom_range(1));
        r.uart_cause    = CAUSE_W'($urandom_range(3));
        r.timer_pending = 1'($urandom_range(1));
        r.done_tag      = tag;
        r.aim_busy      = aim;
        r.gap           = draw_gap();
        request_q.push_back(r);
    endtask

    task automatic push_cfg(logic idx, logic [PRIO_W-1:0] val);
        request_t r;

        r           = '{kind: ACT_CFG, default: '0};
        r.cfg_index = idx;
        r.cfg_data  = val;
        r.gap       = draw_gap();
        request_q.push_back(r);
    endtask

    task automatic push_drain();
        request_t r;

        r = '{kind: ACT_DRAIN, default: '0};
        request_q.push_back(r);
    endtask

    // Driver: issue queued requests at the falling edge
    always @(negedge clk)
    begin : drive_requests
        logic     nxt_start;
        logic     nxt_cfg;
        request_t r;

        nxt_start = start;
        nxt_cfg   = cfg_valid;
        if (start && req_taken)
            nxt_start = 1'b0;
        if (cfg_valid && cfg_taken)
            nxt_cfg = 1'b0;
        if (rst_n && !nxt_start && !nxt_cfg && request_q.size() > 0)
        begin
            if (!gap_loaded)
            begin
                gap_left   = request_q[0].gap;
                gap_loaded = 1'b1;
            end
            if (gap_left > 0)
                gap_left--;
            else
            begin
                r = request_q[0];
                case (r.kind)
                    ACT_ITEM:
                    begin
                        if (r.aim_busy)
                            r.done_tag = pick_busy_slot(r.done_tag);
                        op            <= r.op;
                        uart_pending  <= r.uart_pending;
                        uart_cause    <= r.uart_cause;
                        timer_pending <= r.timer_pending;
                        done_tag      <= r.done_tag;
                        nxt_start     = 1'b1;
                        void'(request_q.pop_front());
                        gap_loaded    = 1'b0;
                    end
                    ACT_CFG:
                    begin
                        // Write registers only once the block is idle
                        if (outcome_q.size() == 0 && !busy)
                        begin
                            cfg_index  <= r.cfg_index;
                            cfg_data   <= r.cfg_data;
                            nxt_cfg    = 1'b1;
                            void'(request_q.pop_front());
                            gap_loaded = 1'b0;
                        end
                    end
                    ACT_DRAIN:
                    begin
                        if (outcome_q.size() == 0)
                        begin
                            void'(request_q.pop_front());
                            gap_loaded = 1'b0;
                        end
                    end
                    default:
                    begin
                        void'(request_q.pop_front());
                        gap_loaded = 1'b0;
                    end
                endcase
            end
        end
        start     <= nxt_start;
        cfg_valid <= nxt_cfg;
    end

    // Monitor: check results, track register writes, predict taken requests
    always @(posedge clk)
    begin : watch_results
        step_outcome_t want_o;

        if (rst_n)
        begin
            if (result_valid)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch("result with no request pending");
                else
                begin
                    want_o = outcome_q.pop_front();
                    check_field("mask_uart_tx", mask_uart_tx, want_o.mask_tx);
                    check_field("mask_uart_rx", mask_uart_rx, want_o.mask_rx);
                    check_field("mask_timer", mask_timer, want_o.mask_tm);
                    check_field("start_valid", start_valid, want_o.s_valid);
                    check_field("start_handler", start_handler, want_o.s_handler);
                    check_field("start_tag", start_tag, want_o.s_tag);
                    check_field("dropped", dropped, want_o.drop);
                    check_field("queued_count", queued_count, want_o.count);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_UART_PRIO)
                    uart_prio = cfg_data;
                else
                    timer_prio = cfg_data;
            end
            if (start && !busy)
                outcome_q.push_back(advance_task_table(op, uart_pending, uart_cause,
                                                       timer_pending, done_tag));
        end
        req_taken <= rst_n && start && !busy;
        cfg_taken <= rst_n && cfg_valid && cfg_ready;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("irq_priority_task_queue_unit_tb: errors");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int                ph;
        int                n;
        int                irq_pct;
        int                pick;
        logic [PRIO_W-1:0] u_val;
        logic [PRIO_W-1:0] t_val;

        // Directed: ignored events, equal priorities, full table
        push_done(3'd7, 1'b0);
        push_irq(1'b1, 2'd0, 1'b1);
        push_irq(1'b1, 2'd3, 1'b0);
        push_irq(1'b0, 2'd1, 1'b0);
        push_irq(1'b0, 2'd0, 1'b1);
        push_irq(1'b1, CAUSE_TX, 1'b1);
        push_irq(1'b1, CAUSE_RX, 1'b0);
        push_done(3'd2, 1'b0);
        push_done(3'd0, 1'b0);
        repeat (6)
            push_irq(1'b0, 2'd0, 1'b1);
        push_irq(1'b0, 2'd2, 1'b1);
        push_irq(1'b1, CAUSE_RX, 1'b0);
        push_irq(1'b1, CAUSE_TX, 1'b1);
        push_done(3'd1, 1'b0);
        push_done(3'd2, 1'b0);
        push_done(3'd0, 1'b0);

        // Random phases, each with its own priority setting
        for (ph = 0; ph < PHASES; ph++)
        begin
            push_drain();
            case (ph)
                0:       begin u_val = 8'd255; t_val = 8'd0;   end
                1:       begin u_val = 8'd0;   t_val = 8'd0;   end
                2:       begin u_val = 8'd255; t_val = 8'd255; end
                3:       begin u_val = 8'd0;   t_val = 8'd255; end
                default:
                begin
                    u_val = PRIO_W'($urandom_range(255));
                    t_val = PRIO_W'($urandom_range(255));
                end
            endcase
            if ($urandom_range(1))
            begin
                push_cfg(REG_UART_PRIO, u_val);
                push_cfg(REG_TIMER_PRIO, t_val);
            end
            else
            begin
                push_cfg(REG_TIMER_PRIO, t_val);
                push_cfg(REG_UART_PRIO, u_val);
            end
            irq_pct = $urandom_range(70, 35);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < irq_pct)
                begin
                    pick = $urandom_range(9);
                    push_irq(1'($urandom_range(1)),
                             (pick < 4) ? CAUSE_TX : (pick < 8) ? CAUSE_RX :
                                          ((pick == 8) ? 2'd0 : 2'd3),
                             1'($urandom_range(1)));
                end
                else
                    push_done(TAG_W'($urandom_range(7)), $urandom_range(99) < 80);
            end
        end

        // Hold reset, then release away from the sampling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (request_q.size() > 0 || start || cfg_valid || outcome_q.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0)
            $display("irq_priority_task_queue_unit_tb: clean");
        else
            $display("irq_priority_task_queue_unit_tb: errors");
        $finish;
    end

endmodule

// ===== irq_priority_task_queue_unit.f =====
+incdir+src
src/iptq_pkg.sv
src/iptq_ctrl.sv
src/iptq_datapath.sv
src/irq_priority_task_queue_unit.sv
src/iptq_checker.sv
bench/irq_priority_task_queue_unit_tb.sv
